FILE: sv/address_lock_table_unit_defines.svh
// Assertion macros used by the lock table checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ADDRESS_LOCK_TABLE_UNIT_DEFINES_SVH
`define ADDRESS_LOCK_TABLE_UNIT_DEFINES_SVH

// Implication in the same cycle, disabled during reset.
`define ALT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, disabled during reset.
`define ALT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle that also covers the reset cycles.
`define ALT_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/alt_pkg.sv
// Types, codes and the hash function of the address lock table.
// No dependencies; used by every module of the block but alt_ram.
package alt_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 64;
  localparam int ENTRY_W     = KEY_W + 1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_GRANTED   = 3'd0,
    STS_BUSY      = 3'd1,
    STS_RELEASED  = 3'd2,
    STS_FULL      = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_ZERO_KEY  = 3'd5,
    STS_CLEARED   = 3'd6,
    STS_NOT_HELD  = 3'd7
  } status_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_PROBE
  } seq_state_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] slot_index;
    logic       new_entry;
  } result_t;

  typedef struct packed {
    logic    held;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic room;
  } outq_status_t;

  // TABLE_SLOTS is a power of two, so the modulo is a mask.
  function automatic slot_t start_slot(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] h;
    h = (key >> 3) ^ (key >> 7) ^ (key >> 11);
    return h[SLOT_W-1:0];
  endfunction

endpackage

FILE: sv/alt_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
module alt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/alt_outq.sv
// Two-word result queue between the probe sequencer and the out_ port.
// Depends on alt_pkg for the result and status types.
module alt_outq
  import alt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  result_t      push_res,
  output outq_status_t qstat,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_res
);

  logic [1:0] count_r, count_nxt;
  result_t    head_r, head_nxt;
  result_t    tail_r, tail_nxt;
  logic       pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count_r != 2'd0);
  assign out_res    = head_r;
  assign qstat.room = (count_r != 2'd2);

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_res;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_res;
        end else if (push) begin
          tail_nxt  = push_res;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          head_nxt  = tail_r;
          count_nxt = 2'd1;
        end
      end
      default: begin
        count_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

FILE: sv/alt_seq.sv
// Probe sequencer: hashes the key, walks the table one slot per cycle
// through the entry RAM and writes back the held mark. Depends on alt_pkg.
module alt_seq
  import alt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [KEY_W-1:0] in_key_address,
  input  outq_status_t     qstat,
  output logic             push,
  output result_t          push_res,
  output logic             ram_we,
  output slot_t            ram_waddr,
  output entry_t           ram_wdata,
  output slot_t            ram_raddr,
  input  entry_t           ram_rdata
);

  seq_state_t             state_r, state_nxt;
  logic                   acq_r, acq_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  slot_t                  idx_r, idx_nxt;
  slot_t                  cnt_r, cnt_nxt;
  logic [TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic                   take, hit, empty, last;

  assign in_ready = (state_r == SEQ_IDLE) && qstat.room;
  assign take     = in_valid && in_ready;
  assign empty    = !valid_r[idx_r];
  assign hit      = valid_r[idx_r] && (ram_rdata.key == key_r);
  assign last     = (cnt_r == SLOT_W'(TABLE_SLOTS - 1));

  always_comb begin
    state_nxt = state_r;
    acq_nxt   = acq_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    push      = 1'b0;
    push_res  = '{status: STS_GRANTED, slot_index: 8'd0, new_entry: 1'b0};
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '{held: 1'b1, key: key_r};
    ram_raddr = idx_r;
    case (state_r)
      SEQ_IDLE: begin
        ram_raddr = start_slot(in_key_address);
        if (take) begin
          case (in_operation)
            OP_CLEAR: begin
              valid_nxt       = '0;
              push            = 1'b1;
              push_res.status = STS_CLEARED;
            end
            OP_ACQUIRE, OP_RELEASE: begin
              if (in_key_address == '0) begin
                push            = 1'b1;
                push_res.status = STS_ZERO_KEY;
              end else begin
                state_nxt = SEQ_PROBE;
                acq_nxt   = (in_operation == OP_ACQUIRE);
                key_nxt   = in_key_address;
                idx_nxt   = start_slot(in_key_address);
                cnt_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_PROBE: begin
        if (hit) begin
          push                = 1'b1;
          push_res.slot_index = 8'(idx_r);
          state_nxt           = SEQ_IDLE;
          if (acq_r) begin
            if (ram_rdata.held) begin
              push_res.status = STS_BUSY;
            end else begin
              ram_we          = 1'b1;
              push_res.status = STS_GRANTED;
            end
          end else begin
            if (!ram_rdata.held) begin
              push_res.status = STS_NOT_HELD;
            end else begin
              ram_we          = 1'b1;
              ram_wdata.held  = 1'b0;
              push_res.status = STS_RELEASED;
            end
          end
        end else if (empty) begin
          push      = 1'b1;
          state_nxt = SEQ_IDLE;
          if (acq_r) begin
            ram_we              = 1'b1;
            valid_nxt[idx_r]    = 1'b1;
            push_res.status     = STS_GRANTED;
            push_res.slot_index = 8'(idx_r);
            push_res.new_entry  = 1'b1;
          end else begin
            push_res.status = STS_NOT_FOUND;
          end
        end else if (last) begin
          push            = 1'b1;
          state_nxt       = SEQ_IDLE;
          push_res.status = acq_r ? STS_FULL : STS_NOT_FOUND;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    acq_r <= acq_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

FILE: sv/address_lock_table_unit.sv
// Address lock table: a try-lock table of 256 slots keyed by a 64-bit address,
// open addressing with linear probing. One request is worked on at a time.
// Clear and zero-key requests are answered without a probe; a request with the
// unused code is taken but gets no result. Acquire and release probe from 1 up
// to 256 slots, reading the entry RAM once per probed slot through its
// registered read port. A two-word result queue lets a new request in
// while an earlier result waits on out_ready. Depends on alt_pkg, alt_ram,
// alt_seq and alt_outq.
module address_lock_table_unit
  import alt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [KEY_W-1:0] in_key_address,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot_index,
  output logic             out_new_entry
);

  outq_status_t qstat;
  logic         push;
  result_t      push_res;
  result_t      out_res;
  logic         ram_we;
  slot_t        ram_waddr;
  slot_t        ram_raddr;
  entry_t       ram_wdata;
  entry_t       ram_rdata;

  alt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  alt_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_key_address(in_key_address),
    .qstat         (qstat),
    .push          (push),
    .push_res      (push_res),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  alt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .qstat    (qstat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_status     = out_res.status;
  assign out_slot_index = out_res.slot_index;
  assign out_new_entry  = out_res.new_entry;

endmodule

FILE: sv/alt_chk.sv
// Port-level checker for the address lock table, bound to the top level.
// Depends on alt_pkg and address_lock_table_unit_defines.svh.
`include "address_lock_table_unit_defines.svh"

module alt_chk
  import alt_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_slot_index,
  input logic       out_new_entry
);

  `ALT_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result word shown right after reset")
  `ALT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_slot_index) && $stable(out_new_entry), "stalled result word changed")
  `ALT_ASSERT_NOW(a_new_is_grant, out_valid && out_new_entry, out_status == STS_GRANTED, "new entry flagged on a word that is not a grant")
  `ALT_ASSERT_NOW(a_no_slot, out_valid && (out_status == STS_FULL || out_status == STS_NOT_FOUND || out_status == STS_ZERO_KEY || out_status == STS_CLEARED), out_slot_index == 8'd0 && !out_new_entry, "slot or new entry set where no slot applies")

endmodule

bind address_lock_table_unit alt_chk u_alt_chk (.*);
